### sv/gce_pkg.sv
package gce_pkg;

   localparam int unsigned ONE_Q15 = 32768;
   localparam int unsigned ONE_Q14 = 16384;

   typedef enum logic [3:0] {
      CSR_KIND   = 4'd0,
      CSR_COUNT  = 4'd1,
      CSR_ANGLE  = 4'd2,
      CSR_RADIAL = 4'd3,
      CSR_STOP_A = 4'd4,
      CSR_STOP_B = 4'd5,
      CSR_STOP_C = 4'd6,
      CSR_STOP_D = 4'd7
   } csr_index_type;

   typedef enum logic [1:0] {
      KIND_NONE   = 2'd0,
      KIND_LINEAR = 2'd1,
      KIND_RADIAL = 2'd2,
      KIND_UNUSED = 2'd3
   } kind_type;

   // Divider job handed from the sequencer to the shared unit
   typedef struct packed {
      logic        go;
      logic [63:0] num;
      logic [31:0] den;
      logic        sqrt;
   } div_cmd_type;

   typedef struct packed {
      logic        done;
      logic [63:0] quo;
   } div_rsp_type;

   // Quarter-wave sine, Q1.14, index in degrees 0..90
   function automatic logic [14:0] sine_q14(input logic [6:0] d);
      logic [14:0] r;
      case (d)
         7'd0: r = 15'd0;      7'd1: r = 15'd286;    7'd2: r = 15'd572;
         7'd3: r = 15'd857;    7'd4: r = 15'd1143;   7'd5: r = 15'd1428;
         7'd6: r = 15'd1713;   7'd7: r = 15'd1997;   7'd8: r = 15'd2280;
         7'd9: r = 15'd2563;   7'd10: r = 15'd2845;  7'd11: r = 15'd3126;
         7'd12: r = 15'd3406;  7'd13: r = 15'd3686;  7'd14: r = 15'd3964;
         7'd15: r = 15'd4240;  7'd16: r = 15'd4516;  7'd17: r = 15'd4790;
         7'd18: r = 15'd5063;  7'd19: r = 15'd5334;  7'd20: r = 15'd5604;
         7'd21: r = 15'd5872;  7'd22: r = 15'd6138;  7'd23: r = 15'd6402;
         7'd24: r = 15'd6664;  7'd25: r = 15'd6924;  7'd26: r = 15'd7182;
         7'd27: r = 15'd7438;  7'd28: r = 15'd7692;  7'd29: r = 15'd7943;
         7'd30: r = 15'd8192;  7'd31: r = 15'd8438;  7'd32: r = 15'd8682;
         7'd33: r = 15'd8923;  7'd34: r = 15'd9162;  7'd35: r = 15'd9397;
         7'd36: r = 15'd9630;  7'd37: r = 15'd9860;  7'd38: r = 15'd10087;
         7'd39: r = 15'd10311; 7'd40: r = 15'd10531; 7'd41: r = 15'd10749;
         7'd42: r = 15'd10963; 7'd43: r = 15'd11174; 7'd44: r = 15'd11381;
         7'd45: r = 15'd11585; 7'd46: r = 15'd11786; 7'd47: r = 15'd11982;
         7'd48: r = 15'd12176; 7'd49: r = 15'd12365; 7'd50: r = 15'd12551;
         7'd51: r = 15'd12733; 7'd52: r = 15'd12911; 7'd53: r = 15'd13085;
         7'd54: r = 15'd13255; 7'd55: r = 15'd13421; 7'd56: r = 15'd13583;
         7'd57: r = 15'd13741; 7'd58: r = 15'd13894; 7'd59: r = 15'd14044;
         7'd60: r = 15'd14189; 7'd61: r = 15'd14330; 7'd62: r = 15'd14466;
         7'd63: r = 15'd14598; 7'd64: r = 15'd14726; 7'd65: r = 15'd14849;
         7'd66: r = 15'd14968; 7'd67: r = 15'd15082; 7'd68: r = 15'd15191;
         7'd69: r = 15'd15296; 7'd70: r = 15'd15396; 7'd71: r = 15'd15491;
         7'd72: r = 15'd15582; 7'd73: r = 15'd15668; 7'd74: r = 15'd15749;
         7'd75: r = 15'd15826; 7'd76: r = 15'd15897; 7'd77: r = 15'd15964;
         7'd78: r = 15'd16026; 7'd79: r = 15'd16083; 7'd80: r = 15'd16135;
         7'd81: r = 15'd16182; 7'd82: r = 15'd16225; 7'd83: r = 15'd16262;
         7'd84: r = 15'd16294; 7'd85: r = 15'd16322; 7'd86: r = 15'd16344;
         7'd87: r = 15'd16362; 7'd88: r = 15'd16374; 7'd89: r = 15'd16382;
         7'd90: r = 15'd16384;
         default: r = 15'd0;
      endcase
      return r;
   endfunction

   // Signed sine of a whole-degree angle 0..449
   function automatic logic signed [15:0] sin_deg(input logic [8:0] a_in);
      logic [8:0] a;
      logic [8:0] d;
      logic       neg;
      a   = (a_in >= 9'd360) ? a_in - 9'd360 : a_in;
      neg = 1'b0;
      if (a <= 9'd90) begin
         d = a;
      end else if (a <= 9'd180) begin
         d = 9'd180 - a;
      end else if (a <= 9'd270) begin
         d = a - 9'd180;
         neg = 1'b1;
      end else begin
         d = 9'd360 - a;
         neg = 1'b1;
      end
      return neg ? -$signed({1'b0, sine_q14(d[6:0])})
                 : $signed({1'b0, sine_q14(d[6:0])});
   endfunction

endpackage

### sv/gradient_color_evaluator.sv
// Start to result: kind none/unused or fewer than two stops output zero
// colour; t needs no divide for zero radius or a projection at or below zero,
// else linear takes a divide and radial a root then a divide. Blended stops
// take one divide per channel; all use the shared one-bit-per-cycle unit
// (32-step root, 64-step divides). Start is taken the cycle after the result.
// Sync active-high reset clears config, state and valid; no result stall.
module gradient_color_evaluator #(
   parameter int MAX_STOPS = 4
) (
   input  logic                clock,
   input  logic                reset,
   input  logic                start,
   output logic                busy,
   input  logic signed [15:0]  req_pos_x,
   input  logic signed [15:0]  req_pos_y,
   output logic                rsp_valid,
   output logic [7:0]          rsp_red,
   output logic [7:0]          rsp_green,
   output logic [7:0]          rsp_blue,
   output logic [7:0]          rsp_alpha,
   input  logic                csr_write,
   input  logic [3:0]          csr_index,
   input  logic [47:0]         csr_data
);
   import gce_pkg::*;

   localparam int SW = $clog2(MAX_STOPS + 1);
   localparam int IW = $clog2(MAX_STOPS);

   typedef enum logic [7:0] {
      ST_IDLE  = 8'b00000001,
      ST_SQRT  = 8'b00000010,
      ST_RDIV  = 8'b00000100,
      ST_LDIV  = 8'b00001000,
      ST_WALK  = 8'b00010000,
      ST_MUL   = 8'b00100000,
      ST_IDIV  = 8'b01000000,
      ST_OUT   = 8'b10000000
   } state_type;

   // Configuration registers
   logic [1:0]  kind_ff;
   logic [2:0]  count_ff;
   logic [8:0]  angle_ff;
   logic [47:0] radial_ff;
   logic [47:0] stop_ff [MAX_STOPS];

   always_ff @(posedge clock) begin
      if (reset) begin
         kind_ff   <= '0;
         count_ff  <= '0;
         angle_ff  <= '0;
         radial_ff <= '0;
         for (int i = 0; i < MAX_STOPS; i++) stop_ff[i] <= '0;
      end else if (csr_write) begin
         case (csr_index)
            CSR_KIND:   kind_ff   <= csr_data[1:0];
            CSR_COUNT:  count_ff  <= csr_data[2:0];
            CSR_ANGLE:  angle_ff  <= csr_data[8:0];
            CSR_RADIAL: radial_ff <= csr_data;
            default: begin
               if (csr_index >= CSR_STOP_A && csr_index <= CSR_STOP_D &&
                   32'(csr_index - CSR_STOP_A) < MAX_STOPS)
                  stop_ff[IW'(csr_index - CSR_STOP_A)] <= csr_data;
            end
         endcase
      end
   end

   state_type    state_ff, state_in;
   div_cmd_type  cmd;
   div_rsp_type  drsp;
   logic [15:0]  t_ff, t_in;
   logic [IW-1:0] idx_ff, idx_in;
   logic [1:0]   ch_ff, ch_in;
   logic [31:0]  col_ff, col_in;
   logic [16:0]  gap_ff, gap_in;
   logic [16:0]  m_ff, m_in;
   logic [31:0]  prod;
   logic         valid_ff, valid_in;
   logic [SW-1:0] n_eff;

   gce_divider u_div (.clock(clock), .reset(reset), .cmd(cmd), .rsp(drsp));

   // Geometry setup, computed combinationally on start
   logic signed [16:0] dx, dy;
   logic [33:0]        dx2, dy2;
   logic [8:0]         amod;
   logic signed [15:0] sx, sy;
   logic signed [16:0] lo, hi;
   logic signed [47:0] pnum;
   logic [15:0]        off_lo, off_hi;
   logic [7:0]         ca, cb;

   assign n_eff = (32'(count_ff) > MAX_STOPS) ? SW'(MAX_STOPS) : SW'(count_ff);

   always_comb begin
      dx   = 17'(req_pos_x) - 17'($signed(radial_ff[15:0]));
      dy   = 17'(req_pos_y) - 17'($signed(radial_ff[31:16]));
      dx2  = 34'($unsigned(34'(dx) * 34'(dx)));
      dy2  = 34'($unsigned(34'(dy) * 34'(dy)));
      amod = (angle_ff >= 9'd360) ? angle_ff - 9'd360 : angle_ff;
      sx   = sin_deg(amod);
      sy   = -sin_deg(amod + 9'd90);
      lo   = ((sx < 0) ? 17'(sx) : 17'sd0) + ((sy < 0) ? 17'(sy) : 17'sd0);
      hi   = ((sx > 0) ? 17'(sx) : 17'sd0) + ((sy > 0) ? 17'(sy) : 17'sd0);
      pnum = 48'(req_pos_x) * 48'(sx) + 48'(req_pos_y) * 48'(sy)
             - 48'(lo) * 48'sd16384;
      off_lo = stop_ff[idx_ff - IW'(1)][15:0];
      off_hi = stop_ff[idx_ff][15:0];
      ca = stop_ff[idx_ff - IW'(1)][47 - 8 * ch_ff -: 8];
      cb = stop_ff[idx_ff][47 - 8 * ch_ff -: 8];
   end

   // Sequencer
   always_comb begin
      state_in = state_ff;
      t_in     = t_ff;
      idx_in   = idx_ff;
      ch_in    = ch_ff;
      col_in   = col_ff;
      gap_in   = gap_ff;
      m_in     = m_ff;
      prod     = '0;
      valid_in = 1'b0;
      cmd      = '0;
      case (state_ff)
         ST_IDLE: begin
            if (start && !busy) begin
               idx_in = IW'(1);
               ch_in  = '0;
               if (kind_ff == KIND_NONE || kind_ff == KIND_UNUSED || n_eff < SW'(2)) begin
                  col_in   = '0;
                  state_in = ST_OUT;
               end else if (kind_ff == KIND_RADIAL) begin
                  if (radial_ff[47:32] == 16'd0) begin
                     t_in     = 16'(ONE_Q15);
                     state_in = ST_WALK;
                  end else begin
                     cmd.go   = 1'b1;
                     cmd.sqrt = 1'b1;
                     cmd.num  = 64'(dx2 + dy2) << 30;
                     state_in = ST_SQRT;
                  end
               end else begin
                  if (pnum <= 0) begin
                     t_in     = '0;
                     state_in = ST_WALK;
                  end else begin
                     cmd.go   = 1'b1;
                     cmd.num  = 64'({pnum, 1'b0});
                     cmd.den  = 32'(16'(hi - lo));
                     state_in = ST_LDIV;
                  end
               end
            end
         end
         ST_SQRT: begin
            if (drsp.done) begin
               cmd.go   = 1'b1;
               cmd.num  = drsp.quo;
               cmd.den  = 32'(radial_ff[47:32]);
               state_in = ST_RDIV;
            end
         end
         ST_RDIV, ST_LDIV: begin
            if (drsp.done) begin
               t_in = (drsp.quo > 64'(ONE_Q15)) ? 16'(ONE_Q15) : drsp.quo[15:0];
               state_in = ST_WALK;
            end
         end
         ST_WALK: begin
            // one stop per cycle
            if (t_ff <= stop_ff[0][15:0]) begin
               col_in   = stop_ff[0][47:16];
               state_in = ST_OUT;
            end else if (t_ff > off_hi) begin
               if (32'(idx_ff) + 1 >= 32'(n_eff)) begin
                  col_in   = stop_ff[idx_ff][47:16];
                  state_in = ST_OUT;
               end else begin
                  idx_in = idx_ff + IW'(1);
               end
            end else if (off_hi <= off_lo) begin
               col_in   = stop_ff[idx_ff][47:16];
               state_in = ST_OUT;
            end else begin
               gap_in   = 17'(off_hi) - 17'(off_lo);
               m_in     = (t_ff < off_lo) ? 17'd0 : 17'(t_ff) - 17'(off_lo);
               state_in = ST_MUL;
            end
         end
         ST_MUL: begin
            prod     = 32'(ca) * 32'(gap_ff - m_ff) + 32'(cb) * 32'(m_ff)
                       + 32'(gap_ff >> 1);
            state_in = ST_IDIV;
            cmd.go   = 1'b1;
            cmd.num  = 64'(prod);
            cmd.den  = 32'(gap_ff);
         end
         ST_IDIV: begin
            if (drsp.done) begin
               col_in[31 - 8 * ch_ff -: 8] = drsp.quo[7:0];
               if (ch_ff == 2'd3) begin
                  state_in = ST_OUT;
               end else begin
                  ch_in    = ch_ff + 2'd1;
                  state_in = ST_MUL;
               end
            end
         end
         ST_OUT: begin
            valid_in = 1'b1;
            state_in = ST_IDLE;
         end
         default: state_in = ST_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
         valid_ff <= 1'b0;
      end else begin
         state_ff <= state_in;
         valid_ff <= valid_in;
      end
      t_ff    <= t_in;
      idx_ff  <= idx_in;
      ch_ff   <= ch_in;
      col_ff  <= col_in;
      gap_ff  <= gap_in;
      m_ff    <= m_in;
   end

   assign busy      = (state_ff != ST_IDLE) || valid_ff;
   assign rsp_valid = valid_ff;
   assign rsp_red   = col_ff[31:24];
   assign rsp_green = col_ff[23:16];
   assign rsp_blue  = col_ff[15:8];
   assign rsp_alpha = col_ff[7:0];

endmodule

### sv/gce_divider.sv
// Shared radix-2 unit: restoring divide (64 steps) or digit-by-digit
// square root (32 steps), one bit per cycle.
module gce_divider (
   input  logic                clock,
   input  logic                reset,
   input  gce_pkg::div_cmd_type cmd,
   output gce_pkg::div_rsp_type rsp
);
   import gce_pkg::*;

   logic [63:0] num_ff, num_in;
   logic [64:0] rem_ff, rem_in;
   logic [63:0] quo_ff, quo_in;
   logic [31:0] den_ff, den_in;
   logic [6:0]  cnt_ff, cnt_in;
   logic        busy_ff, busy_in;
   logic        sqrt_ff, sqrt_in;
   logic        done_ff, done_in;

   logic [64:0] trial;
   logic [64:0] shifted;

   always_comb begin
      num_in  = num_ff;
      rem_in  = rem_ff;
      quo_in  = quo_ff;
      den_in  = den_ff;
      cnt_in  = cnt_ff;
      busy_in = busy_ff;
      sqrt_in = sqrt_ff;
      done_in = 1'b0;
      trial   = '0;
      shifted = '0;
      if (cmd.go) begin
         num_in  = cmd.num;
         den_in  = cmd.den;
         sqrt_in = cmd.sqrt;
         rem_in  = '0;
         quo_in  = '0;
         cnt_in  = cmd.sqrt ? 7'd32 : 7'd64;
         busy_in = 1'b1;
      end else if (busy_ff) begin
         if (sqrt_ff) begin
            // bring down two bits, trial is 4*root+1
            shifted = {rem_ff[62:0], num_ff[63:62]};
            trial   = {quo_ff[62:0], 2'b01};
            num_in  = {num_ff[61:0], 2'b00};
         end else begin
            shifted = {rem_ff[63:0], num_ff[63]};
            trial   = {33'd0, den_ff};
            num_in  = {num_ff[62:0], 1'b0};
         end
         if (shifted >= trial) begin
            rem_in = shifted - trial;
            quo_in = {quo_ff[62:0], 1'b1};
         end else begin
            rem_in = shifted;
            quo_in = {quo_ff[62:0], 1'b0};
         end
         cnt_in = cnt_ff - 7'd1;
         if (cnt_ff == 7'd1) begin
            busy_in = 1'b0;
            done_in = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
         cnt_ff  <= '0;
      end else begin
         busy_ff <= busy_in;
         done_ff <= done_in;
         cnt_ff  <= cnt_in;
      end
      num_ff  <= num_in;
      rem_ff  <= rem_in;
      quo_ff  <= quo_in;
      den_ff  <= den_in;
      sqrt_ff <= sqrt_in;
   end

   assign rsp.done = done_ff;
   assign rsp.quo  = quo_ff;

endmodule
